// ===== src/universal_cordic_engine_defines.svh =====
// Assertion macros shared by the CORDIC engine RTL.
// No dependencies; pulled in by files that carry concurrent checks.
`ifndef UNIVERSAL_CORDIC_ENGINE_DEFINES_SVH
`define UNIVERSAL_CORDIC_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define UCE_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define UCE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/uce_pkg.sv =====
// Types, angle tables and slot-layout helpers for the CORDIC engine.
// No dependencies.
`default_nettype none

package uce_pkg;

  localparam int TABLE_LEN     = 17;
  localparam int FRACTION_BITS = 16;
  localparam int STEP_W        = 5;
  localparam int DATA_W        = 32;

  typedef enum logic [1:0] {
    COORD_CIRCULAR   = 2'd0,
    COORD_LINEAR     = 2'd1,
    COORD_HYPERBOLIC = 2'd2,
    COORD_INVALID    = 2'd3
  } coord_t;

  typedef struct packed {
    logic [1:0]               cmd;
    logic                     vector_mode;
    logic signed [DATA_W-1:0] x_in;
    logic signed [DATA_W-1:0] y_in;
    logic signed [DATA_W-1:0] z_in;
  } item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x_out;
    logic signed [DATA_W-1:0] y_out;
    logic signed [DATA_W-1:0] z_out;
    logic [STEP_W-1:0]        steps_done;
    logic                     bad_coordinate;
  } result_t;

  // Work item as it travels down the pipe.
  typedef struct packed {
    coord_t                   kind;
    logic                     vector_mode;
    logic                     bad;
    logic [STEP_W-1:0]        n;
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
    logic signed [DATA_W-1:0] z;
  } stage_t;

  localparam logic [15:0] ATAN_TABLE [0:TABLE_LEN-1] = '{
    16'hC90F, 16'h76B1, 16'h3EB6, 16'h1FD5, 16'h0FFA, 16'h07FF, 16'h03FF, 16'h01FF,
    16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001,
    16'h0000
  };

  localparam logic [15:0] ATANH_TABLE [0:TABLE_LEN-1] = '{
    16'h8C9F, 16'h4162, 16'h202B, 16'h1005, 16'h0800, 16'h0400, 16'h0200, 16'h0100,
    16'h0080, 16'h0040, 16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001,
    16'h0000
  };

  localparam logic [DATA_W-1:0] FRAC_ONE = DATA_W'(1) << FRACTION_BITS;

  // Hyperbolic steps run twice: 3, 6, 9, 12, 15.
  localparam logic [TABLE_LEN-1:0] HYP_REPEAT = 17'h09248;

  // Number of pipeline slots for a given step count (repeats get a slot).
  function automatic int slot_count(input int max_steps);
    int cnt;
    cnt = 0;
    for (int j = 0; j < TABLE_LEN; j++) begin
      if (j < max_steps) begin
        cnt = cnt + 1 + int'(HYP_REPEAT[j]);
      end
    end
    return cnt;
  endfunction

  // Table step served by a slot.
  function automatic int slot_step(input int slot);
    int cur;
    int res;
    cur = 0;
    res = 0;
    for (int j = 0; j < TABLE_LEN; j++) begin
      if (cur == slot) res = j;
      cur = cur + 1;
      if (HYP_REPEAT[j]) begin
        if (cur == slot) res = j;
        cur = cur + 1;
      end
    end
    return res;
  endfunction

  // True when a slot is the second pass of a hyperbolic step.
  function automatic bit slot_is_repeat(input int slot);
    int cur;
    bit res;
    cur = 0;
    res = 1'b0;
    for (int j = 0; j < TABLE_LEN; j++) begin
      cur = cur + 1;
      if (HYP_REPEAT[j]) begin
        if (cur == slot) res = 1'b1;
        cur = cur + 1;
      end
    end
    return res;
  endfunction

  // Arithmetic shift right that truncates toward zero.
  function automatic logic signed [DATA_W-1:0] trunc_shift(
      input logic signed [DATA_W-1:0] v, input int p);
    logic signed [DATA_W-1:0] sh;
    logic [DATA_W-1:0]        mask;
    logic                     fix;
    sh   = v >>> p;
    mask = (DATA_W'(1) << p) - DATA_W'(1);
    fix  = v[DATA_W-1] && ((v & mask) != '0);
    return sh + {{(DATA_W-1){1'b0}}, fix};
  endfunction

endpackage

`default_nettype wire

// ===== src/uce_entry.sv =====
// Entry register: decodes the coordinate code and caps the step count.
// Depends on uce_pkg.
`default_nettype none

module uce_entry #(
  parameter int MAX_STEPS = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        item_valid,
  input  wire uce_pkg::item_t              item,
  output logic                             item_stall,
  input  wire logic [uce_pkg::STEP_W-1:0]  limit,
  output logic                             dn_valid,
  output uce_pkg::stage_t                  dn_item,
  input  wire logic                        dn_ready
);

  localparam logic [uce_pkg::STEP_W-1:0] STEP_CAP = uce_pkg::STEP_W'(MAX_STEPS);

  logic            valid;
  uce_pkg::stage_t stage;
  uce_pkg::stage_t stage_next;
  logic            up_ready;

  assign up_ready   = !valid || dn_ready;
  assign item_stall = !up_ready;

  always_comb begin
    stage_next.kind        = uce_pkg::coord_t'(item.cmd);
    stage_next.vector_mode = item.vector_mode;
    stage_next.bad         = (uce_pkg::coord_t'(item.cmd) == uce_pkg::COORD_INVALID);
    stage_next.x           = item.x_in;
    stage_next.y           = item.y_in;
    stage_next.z           = item.z_in;
    if (stage_next.bad) begin
      stage_next.n = '0;
    end else if (limit > STEP_CAP) begin
      stage_next.n = STEP_CAP;
    end else begin
      stage_next.n = limit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && item_valid) begin
      stage <= stage_next;
    end
  end

  assign dn_valid = valid;
  assign dn_item  = stage;

endmodule

`default_nettype wire

// ===== src/uce_stage.sv =====
// One CORDIC micro-rotation slot with its pipeline register.
// Depends on uce_pkg.
`default_nettype none

module uce_stage #(
  parameter int STEP_J    = 0,
  parameter bit IS_REPEAT = 1'b0
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  input  wire uce_pkg::stage_t  up_item,
  output logic                  up_ready,
  output logic                  dn_valid,
  output uce_pkg::stage_t       dn_item,
  input  wire logic             dn_ready
);

  localparam int SHIFT_C = STEP_J;
  localparam int SHIFT_H = STEP_J + 1;
  localparam logic [uce_pkg::STEP_W-1:0] STEP_IDX = uce_pkg::STEP_W'(STEP_J);
  localparam logic [uce_pkg::DATA_W-1:0] ANG_C =
      {{(uce_pkg::DATA_W-16){1'b0}}, uce_pkg::ATAN_TABLE[STEP_J]};
  localparam logic [uce_pkg::DATA_W-1:0] ANG_H =
      {{(uce_pkg::DATA_W-16){1'b0}}, uce_pkg::ATANH_TABLE[STEP_J]};
  localparam logic [uce_pkg::DATA_W-1:0] ANG_L = uce_pkg::FRAC_ONE >> STEP_J;

  logic                             valid;
  uce_pkg::stage_t                  stage;
  uce_pkg::stage_t                  stage_next;
  logic signed [uce_pkg::DATA_W-1:0] tx;
  logic signed [uce_pkg::DATA_W-1:0] ty;
  logic signed [uce_pkg::DATA_W-1:0] angle;
  logic                             neg;
  logic                             active;
  logic                             hyp;

  assign up_ready = !valid || dn_ready;
  assign hyp      = (up_item.kind == uce_pkg::COORD_HYPERBOLIC);

  always_comb begin
    tx = hyp ? uce_pkg::trunc_shift(up_item.x, SHIFT_H)
             : uce_pkg::trunc_shift(up_item.x, SHIFT_C);
    ty = hyp ? uce_pkg::trunc_shift(up_item.y, SHIFT_H)
             : uce_pkg::trunc_shift(up_item.y, SHIFT_C);

    case (up_item.kind)
      uce_pkg::COORD_CIRCULAR:   angle = ANG_C;
      uce_pkg::COORD_HYPERBOLIC: angle = ANG_H;
      default:                   angle = ANG_L;
    endcase

    // Vectoring drives y toward zero; rotation drives z toward zero.
    if (up_item.vector_mode) begin
      neg = !up_item.y[uce_pkg::DATA_W-1] && (up_item.y != '0);
    end else begin
      neg = up_item.z[uce_pkg::DATA_W-1];
    end

    active = !up_item.bad && (STEP_IDX < up_item.n) && (!IS_REPEAT || hyp);

    stage_next = up_item;
    if (active) begin
      case (up_item.kind)
        uce_pkg::COORD_CIRCULAR:   stage_next.x = neg ? up_item.x + ty : up_item.x - ty;
        uce_pkg::COORD_HYPERBOLIC: stage_next.x = neg ? up_item.x - ty : up_item.x + ty;
        default:                   stage_next.x = up_item.x;
      endcase
      stage_next.y = neg ? up_item.y - tx : up_item.y + tx;
      stage_next.z = neg ? up_item.z + angle : up_item.z - angle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      stage <= stage_next;
    end
  end

  assign dn_valid = valid;
  assign dn_item  = stage;

endmodule

`default_nettype wire

// ===== src/uce_out.sv =====
// Result register: formats the finished item for the output channel.
// Depends on uce_pkg.
`default_nettype none

module uce_out (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             up_valid,
  input  wire uce_pkg::stage_t  up_item,
  output logic                  up_ready,
  output logic                  result_valid,
  output uce_pkg::result_t      result,
  input  wire logic             result_stall
);

  logic             valid;
  uce_pkg::result_t res;
  uce_pkg::result_t res_next;

  assign up_ready = !valid || !result_stall;

  always_comb begin
    res_next.x_out          = up_item.x;
    res_next.y_out          = up_item.y;
    res_next.z_out          = up_item.z;
    res_next.steps_done     = up_item.n;
    res_next.bad_coordinate = up_item.bad;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      res <= res_next;
    end
  end

  assign result_valid = valid;
  assign result       = res;

endmodule

`default_nettype wire

// ===== src/universal_cordic_engine.sv =====
// Top level of the pipelined Q16.16 CORDIC engine.
// Depends on uce_pkg, uce_entry, uce_stage, uce_out and the defines header.
//
//  channel  | signals                        | direction | transfer when
//  ---------+--------------------------------+-----------+----------------------
//  item     | item_valid, item, item_stall   | in        | valid && !stall
//  result   | result_valid, result, r._stall | out       | valid && !stall
//  cfg      | cfg_valid, cfg_data, cfg_ready | in        | valid && ready
//
// One item per cycle sustained while the result channel is not stalled. SLOTS is
// MAX_STEPS plus one extra slot per hyperbolic repeat (22 at MAX_STEPS 17). Pipe:
// one entry register, one register per micro-rotation slot, one result register.
// Synchronous reset clears all valid bits and sets the step limit to 17.
// Each stage holds while its successor is full and stalled, so a stalled result
// only backs up as far as needed; bubbles are squeezed out and nothing repeats.
`default_nettype none
`include "universal_cordic_engine_defines.svh"

module universal_cordic_engine #(
  parameter int MAX_STEPS = 17
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // item channel
  input  wire logic                        item_valid,
  input  wire uce_pkg::item_t              item,
  output logic                             item_stall,
  // result channel
  output logic                             result_valid,
  output uce_pkg::result_t                 result,
  input  wire logic                        result_stall,
  // configuration: iteration limit
  input  wire logic                        cfg_valid,
  input  wire logic [uce_pkg::STEP_W-1:0]  cfg_data,
  output logic                             cfg_ready
);

  // Slot layout: circular/linear use the plain slots, hyperbolic also the
  // repeat slots placed directly after steps 3, 6, 9, 12 and 15.
  localparam int SLOTS = uce_pkg::slot_count(MAX_STEPS);

  logic [uce_pkg::STEP_W-1:0] iteration_limit;

  uce_pkg::stage_t pipe_item  [SLOTS+1];
  logic            pipe_valid [SLOTS+1];
  logic            pipe_ready [SLOTS+1];

  // The limit register is always writable; the user must write it only while idle (not enforced).
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_limit <= uce_pkg::STEP_W'(17);
    end else if (cfg_valid && cfg_ready) begin
      iteration_limit <= cfg_data;
    end
  end

  // Entry: decode cmd, capture the effective step count with the item.
  uce_entry #(
    .MAX_STEPS (MAX_STEPS)
  ) u_entry (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .limit      (iteration_limit),
    .dn_valid   (pipe_valid[0]),
    .dn_item    (pipe_item[0]),
    .dn_ready   (pipe_ready[0])
  );

  // One micro-rotation per slot; an inactive slot just forwards the item.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    uce_stage #(
      .STEP_J    (uce_pkg::slot_step(s)),
      .IS_REPEAT (uce_pkg::slot_is_repeat(s))
    ) u_stage (
      .clk      (clk),
      .rst      (rst),
      .up_valid (pipe_valid[s]),
      .up_item  (pipe_item[s]),
      .up_ready (pipe_ready[s]),
      .dn_valid (pipe_valid[s+1]),
      .dn_item  (pipe_item[s+1]),
      .dn_ready (pipe_ready[s+1])
    );
  end

  // Result register drives the output; the output stall reaches the pipe through its ready.
  uce_out u_out (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (pipe_valid[SLOTS]),
    .up_item      (pipe_item[SLOTS]),
    .up_ready     (pipe_ready[SLOTS]),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall)
  );

  // An empty entry register can always take a transfer.
  `UCE_ASSERT_SAME(a_entry_free, clk, rst, !pipe_valid[0], !item_stall,
                   "item stalled with empty entry register")

  // Invalid coordinate never reports steps.
  `UCE_ASSERT_SAME(a_bad_no_steps, clk, rst, result_valid && result.bad_coordinate,
                   result.steps_done == '0, "bad coordinate with nonzero step count")

  // Reported step count never exceeds the pipe depth in table steps.
  `UCE_ASSERT_SAME(a_steps_bound, clk, rst, result_valid,
                   result.steps_done <= uce_pkg::STEP_W'(MAX_STEPS),
                   "step count above MAX_STEPS")

  // A configuration transfer lands in the limit register.
  `UCE_ASSERT_NEXT(a_cfg_write, clk, rst, cfg_valid && cfg_ready,
                   iteration_limit == $past(cfg_data), "limit register not updated")

endmodule

`default_nettype wire

// ===== sim/universal_cordic_engine_test.sv =====
// Self-checking testbench for the Q16.16 CORDIC engine: directed and random
// items across several step limits, with a queued driver and a result monitor.
// Depends on uce_pkg and universal_cordic_engine.
`timescale 1ns / 100ps

module universal_cordic_engine_test;

  localparam int TABLE_STEPS  = 17;
  localparam int IDLE_LIMIT   = 4000;   // cycles with no transfer of any kind
  localparam int DRAIN_CYCLES = 40;     // pipe is 24 deep at 17 steps
  localparam int SHOW_LIMIT   = 10;

  // Angle tables, Q16.16, indexed by table step.
  localparam logic [15:0] CIRC_ANGLE [0:16] = '{
    16'hC90F, 16'h76B1, 16'h3EB6, 16'h1FD5, 16'h0FFA, 16'h07FF, 16'h03FF, 16'h01FF,
    16'h00FF, 16'h007F, 16'h003F, 16'h001F, 16'h000F, 16'h0007, 16'h0003, 16'h0001,
    16'h0000
  };
  localparam logic [15:0] HYP_ANGLE [0:16] = '{
    16'h8C9F, 16'h4162, 16'h202B, 16'h1005, 16'h0800, 16'h0400, 16'h0200, 16'h0100,
    16'h0080, 16'h0040, 16'h0020, 16'h0010, 16'h0008, 16'h0004, 16'h0002, 16'h0001,
    16'h0000
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       item_valid = 1'b0;
  uce_pkg::item_t             item = '0;
  logic                       item_stall;
  logic                       result_valid;
  uce_pkg::result_t           result;
  logic                       result_stall = 1'b0;
  logic                       cfg_valid = 1'b0;
  logic [uce_pkg::STEP_W-1:0] cfg_data = '0;
  logic                       cfg_ready;

  uce_pkg::item_t   pending_items[$];
  uce_pkg::result_t predicted_results[$];
  logic [4:0]  step_limit = 5'd17;     // mirror of the engine's limit register
  int          mismatches = 0;
  int          results_checked = 0;
  int          idle_cycles = 0;
  int          coord_seen[4] = '{0, 0, 0, 0};
  int          limits_run = 1;
  int          burst_left = 0;
  int          gap_left = 0;
  int unsigned stall_tick = 0;
  int          stall_mode = 0;

  universal_cordic_engine DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item         (item),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result       (result),
    .result_stall (result_stall),
    .cfg_valid    (cfg_valid),
    .cfg_data     (cfg_data),
    .cfg_ready    (cfg_ready)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Expected-value computation
  // ---------------------------------------------------------------------------

  // Divide by 2^p, rounding toward zero (not floor, unlike a plain >>>).
  function automatic logic signed [31:0] shift_trunc(input logic signed [31:0] v,
                                                     input int p);
    logic signed [63:0] q;
    q = 64'(v) / (64'sd1 <<< p);
    return q[31:0];
  endfunction

  function automatic uce_pkg::result_t cordic_predict(input uce_pkg::item_t it,
                                                      input logic [4:0] limit);
    logic signed [31:0] x, y, z, dx, dy, ang;
    int      steps, sh, reps;
    logic    flip;
    uce_pkg::result_t r;
    x = it.x_in;
    y = it.y_in;
    z = it.z_in;
    // Invalid system: straight pass-through, flagged, no steps.
    if (it.cmd == uce_pkg::COORD_INVALID) begin
      r.x_out = x;
      r.y_out = y;
      r.z_out = z;
      r.steps_done = '0;
      r.bad_coordinate = 1'b1;
      return r;
    end
    // Limits above the table run the whole table.
    steps = (limit > TABLE_STEPS) ? TABLE_STEPS : int'(limit);
    for (int j = 0; j < steps; j++) begin
      // Hyperbolic steps 3, 6, 9, 12, 15 run twice for convergence.
      reps = (it.cmd == uce_pkg::COORD_HYPERBOLIC && j != 0 && j % 3 == 0) ? 2 : 1;
      for (int k = 0; k < reps; k++) begin
        sh = (it.cmd == uce_pkg::COORD_HYPERBOLIC) ? j + 1 : j;
        case (it.cmd)
          uce_pkg::COORD_CIRCULAR:   ang = {16'h0, CIRC_ANGLE[j]};
          uce_pkg::COORD_HYPERBOLIC: ang = {16'h0, HYP_ANGLE[j]};
          default:                   ang = 32'h0001_0000 >> j;
        endcase
        // Rotation steers on sign of z, vectoring drives y toward zero.
        flip = it.vector_mode ? (y > 0) : (z < 0);
        dy = (it.cmd == uce_pkg::COORD_LINEAR) ? 32'sd0 : shift_trunc(y, sh);
        dx = shift_trunc(x, sh);
        if (flip) begin
          dy  = -dy;
          dx  = -dx;
          ang = -ang;
        end
        if (it.cmd == uce_pkg::COORD_CIRCULAR) begin
          x = x - dy;
        end else if (it.cmd == uce_pkg::COORD_HYPERBOLIC) begin
          x = x + dy;
        end
        y = y + dx;
        z = z - ang;
      end
    end
    r.x_out = x;
    r.y_out = y;
    r.z_out = z;
    r.steps_done = 5'(steps);
    r.bad_coordinate = 1'b0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic uce_pkg::item_t make_item(input uce_pkg::coord_t sys, input logic vec,
                                               input logic [31:0] x, input logic [31:0] y,
                                               input logic [31:0] z);
    uce_pkg::item_t it;
    it.cmd = sys;
    it.vector_mode = vec;
    it.x_in = x;
    it.y_in = y;
    it.z_in = z;
    return it;
  endfunction

  // Mostly values in a sane Q16.16 range, with full-width and edge values mixed in.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
      4, 5, 6:    return $urandom();
      7:          return 32'h7FFF_FFFF;
      8:          return 32'h8000_0000;
      default:    return 32'($urandom_range(0, 3)) - 32'd2;
    endcase
  endfunction

  function automatic uce_pkg::item_t rand_item();
    uce_pkg::coord_t sys;
    case ($urandom_range(0, 15))
      0, 1, 2, 3, 4:     sys = uce_pkg::COORD_CIRCULAR;
      5, 6, 7, 8:        sys = uce_pkg::COORD_LINEAR;
      9, 10, 11, 12, 13: sys = uce_pkg::COORD_HYPERBOLIC;
      default:           sys = uce_pkg::COORD_INVALID;
    endcase
    return make_item(sys, 1'($urandom_range(0, 1)), rand_word(), rand_word(),
                     rand_word());
  endfunction

  // Sender holds off until every queued item went in and every result came out.
  task automatic wait_drained();
    while (pending_items.size() != 0 || item_valid || predicted_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_limit(input logic [4:0] v);
    cfg_data  <= v;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid  <= 1'b0;
    step_limit = v;
    limits_run++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOW_LIMIT)
        $display("%0t: %s mismatch, expected %h got %h", $realtime, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Item driver: bursts of random length separated by random gaps.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        predicted_results.push_back(cordic_predict(item, step_limit));
        coord_seen[item.cmd]++;
      end
      // A stalled item stays on the bus untouched.
      if (!(item_valid && item_stall)) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          if (gap_left != 0) gap_left--;
          item_valid <= 1'b0;
        end else begin
          item       <= pending_items.pop_front();
          item_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: stall pattern that switches between random styles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    stall_tick++;
    if (stall_tick % 128 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0:       result_stall <= 1'b0;                         // free-flowing
      1:       result_stall <= ($urandom_range(0, 99) < 30);
      2:       result_stall <= (stall_tick % 11) < 8;        // mostly blocked
      default: result_stall <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin : result_monitor
    uce_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (predicted_results.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOW_LIMIT)
          $display("%0t: unexpected result %h", $realtime, result);
      end else begin
        want = predicted_results.pop_front();
        results_checked++;
        check_field("x_out", want.x_out, result.x_out);
        check_field("y_out", want.y_out, result.y_out);
        check_field("z_out", want.z_out, result.z_out);
        check_field("steps_done", 32'(want.steps_done), 32'(result.steps_done));
        check_field("bad_coordinate", 32'(want.bad_coordinate),
                    32'(result.bad_coordinate));
      end
    end
  end

  // Watchdog: too long without any transfer on any channel means a hang.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : sequencer
    logic [4:0] limits [10];
    int         n_items;
    limits = '{5'd0, 5'd31, 5'd1, 5'd18, 5'd5, 5'd12, 5'd16, 5'd9, 5'd17, 5'd0};
    limits[9] = 5'($urandom_range(0, 31));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset limit of 17 steps.
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b0, 32'h0001_0000, 0,
                                      32'h0000_8000));
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b1, 32'h0001_0000,
                                      32'h0001_0000, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_LINEAR, 1'b0, 32'h0002_0000, 0,
                                      32'h0001_8000));
    pending_items.push_back(make_item(uce_pkg::COORD_LINEAR, 1'b1, 32'h0002_0000,
                                      32'h0003_0000, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b0, 32'h0001_3520, 0,
                                      32'h0000_8000));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b1, 32'h0002_0000,
                                      32'h0001_0000, 0));
    // Invalid system in both modes: pass-through with the error flag.
    pending_items.push_back(make_item(uce_pkg::COORD_INVALID, 1'b0, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'hDEAD_BEEF));
    pending_items.push_back(make_item(uce_pkg::COORD_INVALID, 1'b1, 32'h8000_0000,
                                      32'hFFFF_FFFF, 32'h7FFF_FFFF));
    // Field extremes, wrap-around on every sum.
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b0, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF));
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b0, 32'h8000_0000,
                                      32'h7FFF_FFFF, 32'h8000_0000));
    pending_items.push_back(make_item(uce_pkg::COORD_LINEAR, 1'b0, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b1, 32'h7FFF_FFFF,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF));
    // Most negative y while vectoring: treated as negative.
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b1, 32'h0001_0000,
                                      32'h8000_0000, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_LINEAR, 1'b1, 32'h7FFF_FFFF,
                                      32'h8000_0000, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b1, 32'h8000_0000,
                                      32'h8000_0000, 32'h0001_0000));
    // Zero steering value, all zeros, all ones.
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b1, 32'h0003_0000, 0,
                                      32'h0000_1000));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b0, 32'h0001_0000,
                                      32'h0000_4000, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_LINEAR, 1'b0, 0, 0, 0));
    pending_items.push_back(make_item(uce_pkg::COORD_CIRCULAR, 1'b1, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(uce_pkg::COORD_HYPERBOLIC, 1'b0, 32'hFFFF_FFFF,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
    wait_drained();

    // Random phases, one per entry of the limit list, which includes 0 and limits above the table.
    for (int ph = 0; ph < 10; ph++) begin
      write_limit(limits[ph]);
      n_items = $urandom_range(60, 85);
      for (int i = 0; i < n_items; i++) begin
        pending_items.push_back(rand_item());
        // Mid-phase hold-off: let the pipe empty completely, then resume.
        if (ph == 4 && i == n_items / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (predicted_results.size() != 0) begin
      mismatches++;
      $display("%0d expected results never arrived", predicted_results.size());
    end

    $display("Checked %0d results over %0d step limits; circular %0d, linear %0d,",
             results_checked, limits_run, coord_seen[uce_pkg::COORD_CIRCULAR],
             coord_seen[uce_pkg::COORD_LINEAR]);
    $display("hyperbolic %0d, invalid %0d items; %0d mismatches",
             coord_seen[uce_pkg::COORD_HYPERBOLIC], coord_seen[uce_pkg::COORD_INVALID],
             mismatches);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
